### rtl/tsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tsp_pkg;
    localparam int MaxCities = 16;
    localparam int CityBits = 4;
    localparam int NBits = 5;
    localparam int DistBits = 16;
    localparam int CostBits = 20;
    localparam logic [CostBits-1:0] CostMax = {CostBits{1'b1}};
    localparam logic [NBits-1:0] CityCountReset = 5'd16;

    typedef struct packed {
        logic load;
        logic start;
        logic grd;
        logic gcost;
        logic tcost;
        logic rewind;
        logic emit;
        logic accept;
    } tsp_cmd_t;

    typedef struct packed {
        logic grd_done;
        logic cost_done;
        logic pairs_done;
        logic wide;
        logic out_valid;
        logic out_last;
    } tsp_sts_t;
endpackage
`default_nettype wire

### rtl/tsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tsp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             kind,
    input  wire logic             out_ready,
    input  wire tsp_pkg::tsp_sts_t sts,
    output logic                  in_ready,
    output tsp_pkg::tsp_cmd_t     cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_GRD   = 8'b00000010,
        S_GCOST = 8'b00000100,
        S_TCOST = 8'b00001000,
        S_RD    = 8'b00010000,
        S_EMIT  = 8'b00100000,
        S_WAIT  = 8'b01000000,
        S_SPARE = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid && kind) state_next = S_GRD;
            S_GRD:   if (sts.grd_done) state_next = S_GCOST;
            S_GCOST: if (sts.cost_done) state_next = sts.wide ? S_TCOST : S_RD;
            S_TCOST: if (sts.cost_done && sts.pairs_done) state_next = S_RD;
            S_RD:    state_next = S_EMIT;
            S_EMIT:  state_next = S_WAIT;
            S_WAIT:  if (sts.out_valid && out_ready)
                         state_next = sts.out_last ? S_IDLE : S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cmd.load   = in_valid && in_ready && !kind;
        cmd.start  = in_valid && in_ready && kind;
        cmd.grd    = (state_reg == S_GRD);
        cmd.gcost  = (state_reg == S_GCOST);
        cmd.tcost  = (state_reg == S_TCOST);
        cmd.rewind = (state_reg == S_RD);
        cmd.emit   = (state_reg == S_EMIT);
        cmd.accept = (state_reg == S_WAIT) && sts.out_valid && out_ready;
    end

    a_valid_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.out_valid |-> state_reg == S_WAIT) else $error("result outside wait");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !sts.out_valid) else $error("valid in idle");
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
endmodule
`default_nettype wire

### rtl/tsp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tsp_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tsp_pkg::tsp_cmd_t                 cmd,
    input  wire logic [tsp_pkg::CityBits-1:0]      row,
    input  wire logic [tsp_pkg::CityBits-1:0]      col,
    input  wire logic [tsp_pkg::DistBits-1:0]      distance,
    input  wire logic [tsp_pkg::NBits-1:0]         n_cfg,
    output tsp_pkg::tsp_sts_t                      sts,
    output logic [tsp_pkg::NBits-1:0]              position,
    output logic [tsp_pkg::CityBits-1:0]           city,
    output logic [tsp_pkg::CostBits-1:0]           best_cost,
    output logic [tsp_pkg::CostBits-1:0]           greedy_cost,
    output logic                                   is_last
);
    localparam int CB = tsp_pkg::CityBits;
    localparam int NB = tsp_pkg::NBits;
    localparam int CW = tsp_pkg::CostBits;
    localparam int DB = tsp_pkg::DistBits;
    localparam logic [NB-1:0] NMax = NB'(tsp_pkg::MaxCities);

    logic [DB-1:0] mem [0:tsp_pkg::MaxCities*tsp_pkg::MaxCities-1];
    logic [DB-1:0] rd_data;
    logic [2*CB-1:0] rd_addr;

    logic [NB-1:0] n_reg;
    logic [CB-1:0] greedy_reg [0:tsp_pkg::MaxCities-1];
    logic [CB-1:0] best_reg [0:tsp_pkg::MaxCities-1];
    logic [tsp_pkg::MaxCities-1:0] vis_reg;
    logic [NB-1:0] step_reg, c_reg, k_reg, i_reg, j_reg;
    logic [CB-1:0] cur_reg, pick_reg;
    logic found_reg;
    logic [DB-1:0] least_reg;
    logic rd_pend_reg;
    logic [CW:0] sum_reg;
    logic [CW-1:0] gcost_reg, bcost_reg;
    logic [NB-1:0] out_pos_reg;
    logic [CB-1:0] out_city_reg;
    logic out_last_reg, out_valid_reg;

    function automatic logic [CB-1:0] trial_at(input logic [NB-1:0] p,
        input logic [NB-1:0] i, input logic [NB-1:0] j,
        input logic [CB-1:0] gi, input logic [CB-1:0] gj, input logic [CB-1:0] gp);
        logic [CB-1:0] r;
        r = gp;
        if (p == i) r = gj;
        else if (p == j) r = gi;
        return r;
    endfunction

    logic [CB-1:0] ta, tb, g_i, g_j, g_k, g_k1;
    logic [NB-1:0] k1;
    logic [CW:0] sum_add;
    logic take;
    logic [CB-1:0] sel_city;

    always_comb
    begin
        k1   = k_reg + 1'b1;
        g_i  = greedy_reg[i_reg[CB-1:0]];
        g_j  = greedy_reg[j_reg[CB-1:0]];
        g_k  = greedy_reg[k_reg[CB-1:0]];
        g_k1 = (k1 == n_reg) ? '0 : greedy_reg[k1[CB-1:0]];
        if (cmd.tcost)
        begin
            ta = trial_at(k_reg, i_reg, j_reg, g_i, g_j, g_k);
            tb = (k1 == n_reg) ? '0 : trial_at(k1, i_reg, j_reg, g_i, g_j, g_k1);
        end
        else
        begin
            ta = g_k;
            tb = g_k1;
        end
        rd_addr = {cur_reg, c_reg[CB-1:0]};
        if (cmd.gcost || cmd.tcost)
            rd_addr = {ta, tb};
        sum_add = sum_reg + {{(CW+1-DB){1'b0}}, rd_data};
        if (sum_add > {1'b0, tsp_pkg::CostMax})
            sum_add = {1'b0, tsp_pkg::CostMax};
        take = !vis_reg[c_reg[CB-1:0]] && (!found_reg || rd_data < least_reg);
        sel_city = take ? c_reg[CB-1:0] : pick_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[{row, col}] <= distance;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            bcost_reg     <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                n_reg <= (n_cfg < 5'd2) ? 5'd2 : ((n_cfg > NMax) ? NMax : n_cfg);
                vis_reg <= 16'h0001;
                greedy_reg[0] <= '0;
                step_reg <= 5'd1;
                cur_reg <= '0;
                c_reg <= '0;
                found_reg <= 1'b0;
                rd_pend_reg <= 1'b0;
            end
            if (cmd.grd)
            begin
                if (step_reg == n_reg)
                begin
                    k_reg <= '0;
                    sum_reg <= '0;
                    rd_pend_reg <= 1'b0;
                end
                else if (!rd_pend_reg)
                    rd_pend_reg <= 1'b1;
                else
                begin
                    rd_pend_reg <= 1'b0;
                    if (c_reg + 5'd1 == n_reg)
                    begin
                        c_reg <= '0;
                        found_reg <= 1'b0;
                        step_reg <= step_reg + 5'd1;
                        greedy_reg[step_reg[CB-1:0]] <= sel_city;
                        vis_reg[sel_city] <= 1'b1;
                        cur_reg <= sel_city;
                    end
                    else
                    begin
                        c_reg <= c_reg + 5'd1;
                        if (take)
                        begin
                            found_reg <= 1'b1;
                            least_reg <= rd_data;
                            pick_reg  <= c_reg[CB-1:0];
                        end
                    end
                end
            end
            if (cmd.gcost || cmd.tcost)
            begin
                if (!rd_pend_reg)
                    rd_pend_reg <= 1'b1;
                else
                begin
                    rd_pend_reg <= 1'b0;
                    if (k1 == n_reg)
                    begin
                        k_reg <= '0;
                        sum_reg <= '0;
                        if (cmd.gcost)
                        begin
                            gcost_reg <= sum_add[CW-1:0];
                            bcost_reg <= sum_add[CW-1:0];
                            for (int p = 0; p < tsp_pkg::MaxCities; p++)
                                best_reg[p] <= greedy_reg[p];
                            i_reg <= 5'd1;
                            j_reg <= 5'd2;
                        end
                        else
                        begin
                            if (sum_add[CW-1:0] < bcost_reg)
                            begin
                                bcost_reg <= sum_add[CW-1:0];
                                for (int p = 0; p < tsp_pkg::MaxCities; p++)
                                    best_reg[p] <= (NB'(p) == i_reg) ? g_j :
                                                   ((NB'(p) == j_reg) ? g_i : greedy_reg[p]);
                            end
                            if (j_reg + 5'd1 >= n_reg)
                            begin
                                i_reg <= i_reg + 5'd1;
                                j_reg <= i_reg + 5'd2;
                            end
                            else
                                j_reg <= j_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        k_reg <= k1;
                        sum_reg <= sum_add;
                    end
                end
            end
            if (cmd.rewind)
                k_reg <= '0;
            if (cmd.emit)
            begin
                out_pos_reg  <= k_reg;
                out_city_reg <= (k_reg == n_reg) ? '0 : best_reg[k_reg[CB-1:0]];
                out_last_reg <= (k_reg == n_reg);
                out_valid_reg <= 1'b1;
                k_reg <= k_reg + 5'd1;
            end
            if (cmd.accept)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.grd_done   = (step_reg == n_reg);
        sts.cost_done  = rd_pend_reg && (k1 == n_reg);
        sts.pairs_done = (i_reg + 5'd2 >= n_reg) && (j_reg + 5'd1 >= n_reg);
        sts.wide       = (n_reg > 5'd2);
        sts.out_valid  = out_valid_reg;
        sts.out_last   = out_last_reg;
        position       = out_pos_reg;
        city           = out_city_reg;
        is_last        = out_last_reg;
        best_cost      = out_last_reg ? bcost_reg : '0;
        greedy_cost    = out_last_reg ? gcost_reg : '0;
    end

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tcost |-> n_reg > 5'd2 && j_reg > i_reg) else $error("bad pair");
    a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcost |-> n_reg >= 5'd2 && n_reg <= NMax) else $error("city count out of range");
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.grd, cmd.gcost, cmd.tcost, cmd.rewind, cmd.emit}))
        else $error("overlapping phases");
endmodule
`default_nettype wire

### rtl/tsp_greedy_tour_with_swap_search.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake            Payload
// in       in_valid/in_ready    kind, row, col, distance
// out      out_valid/out_ready  position, city, best_cost, greedy_cost, is_last
// cfg      APB                  city_count at address 0
// A load request is written to the distance table when it is accepted. A solve runs
// the nearest neighbor pass, then a tour cost, one table read per edge, over the
// greedy tour and (n-1)(n-2)/2 swap trials, bounded by the single read port.
// Each result is held until out_ready takes it. Reset sets city_count to 16.
module tsp_greedy_tour_with_swap_search (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [3:0]  row,
    input  wire logic [3:0]  col,
    input  wire logic [15:0] distance,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       position,
    output logic [3:0]       city,
    output logic [19:0]      best_cost,
    output logic [19:0]      greedy_cost,
    output logic             is_last
);
    logic [4:0] city_count_reg;
    tsp_pkg::tsp_cmd_t cmd;
    tsp_pkg::tsp_sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {27'd0, city_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            city_count_reg <= tsp_pkg::CityCountReset;
        else if (psel && penable && pwrite && paddr == 2'd0)
            city_count_reg <= pwdata[4:0];
    end

    tsp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .kind(kind),
        .out_ready(out_ready), .sts(sts), .in_ready(in_ready), .cmd(cmd)
    );

    tsp_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .row(row), .col(col),
        .distance(distance), .n_cfg(city_count_reg), .sts(sts),
        .position(position), .city(city), .best_cost(best_cost),
        .greedy_cost(greedy_cost), .is_last(is_last)
    );

    assign out_valid = sts.out_valid;
endmodule
`default_nettype wire
